// File: hw/rtl/obuhs_pkg.sv
// Shared types and constants for the unit-header chain scanner.
`default_nettype none

package obuhs_pkg;

    localparam int POS_W = 16;
    localparam int SIZE_W = 56;
    localparam int SIZE_FIELD_MAX = 8;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } obuhs_in_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  payload_offset;
        logic [SIZE_W-1:0] payload_size;
    } obuhs_out_t;

    typedef struct packed {
        logic       emit;
        obuhs_out_t beat;
    } obuhs_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/obuhs_scan.sv
// Header chain scan state and per-byte update.
`default_nettype none

module obuhs_scan
    import obuhs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire obuhs_in_t  item,
    input  wire logic [3:0] target_type,
    output obuhs_res_t      res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SIZE,
        PH_SKIP,
        PH_RUN,
        PH_DOOMED,
        PH_DONE
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SIZE_W-1:0] acc_reg, acc_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [SIZE_W-1:0] skip_reg, skip_next;
    logic              matched_reg, matched_next;
    logic [POS_W-1:0]  pstart_reg, pstart_next;

    logic [POS_W-1:0]  pos_inc;
    logic [SIZE_W-1:0] acc_new;
    logic [2:0]        cnt_new;
    logic [5:0]        shamt;
    logic              ended;
    logic              hdr_match;

    assign pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign shamt     = 6'(cnt_reg) * 6'd7;
    assign acc_new   = acc_reg | (SIZE_W'(item.data_byte[6:0]) << shamt);
    assign cnt_new   = cnt_reg + 3'd1;
    assign ended     = !item.data_byte[7] || (cnt_new == 3'(SIZE_FIELD_MAX % 8));
    assign hdr_match = (item.data_byte[6:3] == target_type);

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        skip_next    = skip_reg;
        matched_next = matched_reg;
        pstart_next  = pstart_reg;
        res          = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                matched_next = hdr_match;
                pstart_next  = pos_inc;
                if (item.data_byte[1]) begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = PH_SIZE;
                    res.emit   = item.last_byte;
                end else if (hdr_match) begin
                    skip_next  = '0;
                    phase_next = PH_RUN;
                    res.emit   = item.last_byte;
                    res.beat.found          = 1'b1;
                    res.beat.payload_offset = pos_inc;
                end else begin
                    phase_next = PH_DOOMED;
                    res.emit   = item.last_byte;
                end
            end
            PH_SIZE: begin
                acc_next = acc_new;
                cnt_next = cnt_new;
                if (!ended) begin
                    res.emit = item.last_byte;
                end else if (matched_reg) begin
                    res.emit                = 1'b1;
                    res.beat.found          = 1'b1;
                    res.beat.payload_offset = pos_inc;
                    res.beat.payload_size   = acc_new;
                    phase_next              = PH_DONE;
                end else if (acc_new == '0) begin
                    phase_next = PH_HEADER;
                    res.emit   = item.last_byte;
                end else begin
                    skip_next  = acc_new;
                    phase_next = PH_SKIP;
                    res.emit   = item.last_byte;
                end
            end
            PH_SKIP: begin
                if (skip_reg <= SIZE_W'(1)) begin
                    skip_next  = '0;
                    phase_next = PH_HEADER;
                end else begin
                    skip_next = skip_reg - 1'b1;
                end
                res.emit = item.last_byte;
            end
            PH_RUN: begin
                if (skip_reg != SIZE_MAX) begin
                    skip_next = skip_reg + 1'b1;
                end
                res.emit                = item.last_byte;
                res.beat.found          = 1'b1;
                res.beat.payload_offset = pstart_reg;
                res.beat.payload_size   = skip_next;
            end
            PH_DOOMED: begin
                res.emit = item.last_byte;
            end
            PH_DONE: begin
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        if (item.last_byte) begin
            phase_next   = PH_HEADER;
            pos_next     = '0;
            acc_next     = '0;
            cnt_next     = '0;
            skip_next    = '0;
            matched_next = 1'b0;
            pstart_next  = '0;
        end else begin
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            skip_reg    <= '0;
            matched_reg <= 1'b0;
            pstart_reg  <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            skip_reg    <= skip_next;
            matched_reg <= matched_next;
            pstart_reg  <= pstart_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/obu_header_scan_find_type.sv
// Top level of the unit-header chain scanner: input register, scan core, result register.
//
// Streams a buffer one byte per beat and reports the first unit whose type
// equals target_type: found, payload offset and payload size, or a not-found
// beat at the last byte. At most one result beat per buffer. One byte is taken
// every cycle unless a held result on m_ stalls input. A registered input byte
// updates the scan state, and the result register if it emits, at the same edge.
// A result held on m_ stalls input only when the next byte also produces a result.
// User must write target_type via cfg_ only while no buffer is in flight; not enforced.
`default_nettype none

module obu_header_scan_find_type
    import obuhs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_target_type,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire obuhs_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output obuhs_out_t      m_data
);

    logic       cfg_write;
    logic [3:0] target_type_reg;
    logic       in_valid_reg;
    obuhs_in_t  in_item_reg;
    logic       out_valid_reg;
    obuhs_out_t out_beat_reg;
    obuhs_res_t res;
    logic       out_free;
    logic       advance;

    assign cfg_write  = cfg_valid;
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || m_ready;
    assign advance    = in_valid_reg && (!res.emit || out_free);
    assign s_ready    = !in_valid_reg || advance;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_beat_reg;

    obuhs_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .item        (in_item_reg),
        .target_type (target_type_reg),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_type_reg <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                target_type_reg <= cfg_target_type;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && res.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance && res.emit) begin
            out_beat_reg <= res.beat;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/obuhs_chk.sv
// Port-level checker for the unit-header chain scanner, bound to the top level.
`default_nettype none

module obuhs_chk
    import obuhs_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire obuhs_out_t m_data
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.payload_offset == '0 && m_data.payload_size == '0)
        else $error("not-found beat carries nonzero offset or size");

    a_found_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.payload_offset != '0)
        else $error("found beat with payload offset inside the first header");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat after reset");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) && !(s_valid && s_ready) |=> !m_valid)
        else $error("result beat without an accepted byte");

endmodule

bind obu_header_scan_find_type obuhs_chk u_obuhs_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
